### src/rbei_pkg.sv
// shared types, constants and a saturating fixed-point helper for the integrator
package rbei_pkg;

  localparam int BODY_COUNT_DEF    = 64;
  localparam int FRACTION_BITS_DEF = 16;
  localparam int BODY_W            = 6;
  localparam int WORD_W            = 32;
  localparam int MASS_W            = 31;
  localparam int DT_W              = 17;
  localparam int QUEUE_DEPTH       = 2;
  localparam int QCNT_W            = 2;

  typedef enum logic [1:0] {
    KIND_LOAD = 2'd0,
    KIND_SETV = 2'd1,
    KIND_STEP = 2'd2,
    KIND_NONE = 2'd3
  } kind_t;

  typedef struct packed {
    kind_t                     kind;
    logic [BODY_W-1:0]         body;
    logic                      in_range;
    logic signed [WORD_W-1:0]  vx;
    logic signed [WORD_W-1:0]  vy;
    logic signed [WORD_W-1:0]  vz;
    logic [MASS_W-1:0]         mass;
    logic [MASS_W-1:0]         radius;
    logic [DT_W-1:0]           dt;
  } cmd_t;

  typedef struct packed {
    logic [BODY_W-1:0]         body;
    logic signed [WORD_W-1:0]  px;
    logic signed [WORD_W-1:0]  py;
    logic signed [WORD_W-1:0]  pz;
    logic signed [WORD_W-1:0]  vx;
    logic signed [WORD_W-1:0]  vy;
    logic signed [WORD_W-1:0]  vz;
    logic signed [WORD_W-1:0]  sx;
    logic signed [WORD_W-1:0]  sy;
    logic signed [WORD_W-1:0]  sz;
    logic                      sat;
  } res_t;

  typedef enum logic [4:0] {
    ST_IDLE, ST_READ, ST_LATCH,
    ST_ACC_DIV, ST_ACC_WAIT, ST_VEL_MUL, ST_VEL_ADD, ST_POS_MUL, ST_POS_ADD,
    ST_TQ_MUL, ST_TQ_NEG, ST_MR_MUL, ST_MR_LATCH, ST_MRR_MUL, ST_INERTIA, ST_DIV5,
    ST_L_MUL, ST_L_ADD, ST_SPIN_DIV, ST_SPIN_WAIT,
    ST_WRITE, ST_OUT
  } seq_t;

  // clamp a 64-bit signed value into 32 bits
  function automatic logic [WORD_W:0] sat32(input logic signed [63:0] v);
    logic [WORD_W:0] r;
    if (v > 64'sd2147483647)       r = {1'b1, 32'h7fffffff};
    else if (v < -64'sd2147483648) r = {1'b1, 32'h80000000};
    else                           r = {1'b0, v[WORD_W-1:0]};
    return r;
  endfunction

endpackage

### src/rigid_body_euler_integrator.sv
// top level of the sphere body integrator
//  channel | ports                               | transfer when
//  input   | in_valid/in_stall, in_kind..in_step_time | in_valid && !in_stall
//  output  | out_valid/out_stall, out_body_out..out_saturated | out_valid && !out_stall
// a load or set-velocity item runs read, latch, write, out; a step's length is
// set by the one shared 48-step serial divider used up to six times per step
// two command slots queue ahead of the sequencer; one result register follows it
// reset is synchronous and clears control only; tables hold garbage until loaded
module rigid_body_euler_integrator #(
  parameter int BODY_COUNT    = rbei_pkg::BODY_COUNT_DEF,
  parameter int FRACTION_BITS = rbei_pkg::FRACTION_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [1:0]           in_kind,
  input  logic [5:0]           in_body,
  input  logic signed [31:0]   in_vector_x,
  input  logic signed [31:0]   in_vector_y,
  input  logic signed [31:0]   in_vector_z,
  input  logic [30:0]          in_new_mass,
  input  logic [30:0]          in_new_radius,
  input  logic [16:0]          in_step_time,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [5:0]           out_body_out,
  output logic signed [31:0]   out_pos_x,
  output logic signed [31:0]   out_pos_y,
  output logic signed [31:0]   out_pos_z,
  output logic signed [31:0]   out_vel_x,
  output logic signed [31:0]   out_vel_y,
  output logic signed [31:0]   out_vel_z,
  output logic signed [31:0]   out_spin_x,
  output logic signed [31:0]   out_spin_y,
  output logic signed [31:0]   out_spin_z,
  output logic                 out_saturated
);
  import rbei_pkg::*;

  cmd_t cin, q_cmd;
  logic q_valid, q_take;
  res_t res;

  always_comb begin
    cin = '0;
    cin.kind   = kind_t'(in_kind);
    cin.body   = in_body;
    cin.vx     = in_vector_x;
    cin.vy     = in_vector_y;
    cin.vz     = in_vector_z;
    cin.mass   = in_new_mass;
    cin.radius = in_new_radius;
    cin.dt     = in_step_time;
  end

  rbei_front #(.BODY_COUNT(BODY_COUNT)) u_front (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .cmd_in(cin), .q_valid(q_valid), .q_cmd(q_cmd), .q_take(q_take)
  );

  rbei_back #(.BODY_COUNT(BODY_COUNT), .FRACTION_BITS(FRACTION_BITS)) u_back (
    .clk(clk), .rst_n(rst_n), .q_valid(q_valid), .q_cmd(q_cmd), .q_take(q_take),
    .out_valid(out_valid), .out_stall(out_stall), .res(res)
  );

  assign out_body_out  = res.body;
  assign out_pos_x     = res.px;
  assign out_pos_y     = res.py;
  assign out_pos_z     = res.pz;
  assign out_vel_x     = res.vx;
  assign out_vel_y     = res.vy;
  assign out_vel_z     = res.vz;
  assign out_spin_x    = res.sx;
  assign out_spin_y    = res.sy;
  assign out_spin_z    = res.sz;
  assign out_saturated = res.sat;

  a_take_needs_entry: assert property (@(posedge clk) disable iff (!rst_n)
    q_take |-> q_valid) else $error("queue read while empty");
  a_stall_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    (q_valid && !q_take && in_valid && !in_stall) |=> q_valid)
    else $error("queue lost an entry");
  a_no_take_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
    q_take |=> !q_take) else $error("two commands taken back to back");

endmodule

### src/rbei_div.sv
// iterative restoring divider: (|num| << frac) / den, one quotient bit a cycle
module rbei_div #(
  parameter int FRACTION_BITS = rbei_pkg::FRACTION_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  input  logic signed [rbei_pkg::WORD_W-1:0] num,
  input  logic [rbei_pkg::WORD_W-1:0]     den,
  output logic                            done,
  output logic signed [rbei_pkg::WORD_W-1:0] quo,
  output logic                            sat
);
  import rbei_pkg::*;

  localparam int NB  = WORD_W + FRACTION_BITS;
  localparam int CW  = $clog2(NB + 1);

  logic [NB-1:0]   dvd_r, dvd_nxt;
  logic [WORD_W:0] rem_r, rem_nxt;
  logic [NB-1:0]   q_r, q_nxt;
  logic [WORD_W-1:0] den_r;
  logic            neg_r;
  logic [CW-1:0]   cnt_r, cnt_nxt;
  logic            busy_r, busy_nxt;
  logic            done_r;
  logic [WORD_W:0] trial;
  logic [WORD_W-1:0] mag;
  logic [NB-1:0]   qc;
  logic signed [63:0] sres;
  logic [WORD_W:0] sv;

  assign mag   = num[WORD_W-1] ? WORD_W'(-num) : WORD_W'(num);
  assign trial = {rem_r[WORD_W-1:0], dvd_r[NB-1]};

  always_comb begin
    rem_nxt = rem_r;
    dvd_nxt = dvd_r;
    q_nxt   = q_r;
    cnt_nxt = cnt_r;
    busy_nxt = busy_r;
    if (start) begin
      rem_nxt = '0;
      dvd_nxt = {mag, {FRACTION_BITS{1'b0}}};
      q_nxt   = '0;
      cnt_nxt = CW'(NB);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      dvd_nxt = dvd_r << 1;
      if (trial >= {1'b0, den_r}) begin
        rem_nxt = trial - {1'b0, den_r};
        q_nxt   = {q_r[NB-2:0], 1'b1};
      end else begin
        rem_nxt = trial;
        q_nxt   = {q_r[NB-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CW'(1)) busy_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    dvd_r <= dvd_nxt;
    q_r   <= q_nxt;
    if (start) begin
      den_r <= den;
      neg_r <= num[WORD_W-1];
    end
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
      done_r <= busy_r && (cnt_r == CW'(1));
    end
  end

  // quotient limited to 2^31 before the sign is applied
  assign qc   = (q_r > NB'(64'h80000000)) ? NB'(64'h80000000) : q_r;
  assign sres = neg_r ? -$signed(64'(qc)) : $signed(64'(qc));
  assign sv   = sat32(sres);
  assign done = done_r;
  assign quo  = sv[WORD_W-1:0];
  assign sat  = sv[WORD_W];

endmodule

### src/rbei_front.sv
// front end: accepts items, flags whether the body is in range, and queues commands
module rbei_front #(
  parameter int BODY_COUNT = rbei_pkg::BODY_COUNT_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  rbei_pkg::cmd_t       cmd_in,
  output logic                 q_valid,
  output rbei_pkg::cmd_t       q_cmd,
  input  logic                 q_take
);
  import rbei_pkg::*;

  cmd_t             fifo_r [QUEUE_DEPTH];
  logic             wp_r, rp_r;
  logic [QCNT_W-1:0] cnt_r;
  logic             push;
  cmd_t             c;

  assign in_stall = (cnt_r == QCNT_W'(QUEUE_DEPTH));
  assign push     = in_valid && !in_stall;
  assign q_valid  = (cnt_r != '0);
  assign q_cmd    = fifo_r[rp_r];

  always_comb begin
    c = cmd_in;
    c.in_range = (32'(cmd_in.body) < 32'(BODY_COUNT));
  end

  always_ff @(posedge clk) begin
    if (push) fifo_r[wp_r] <= c;
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (q_take) rp_r <= ~rp_r;
      cnt_r <= cnt_r + QCNT_W'(push) - QCNT_W'(q_take);
    end
  end

endmodule

### src/rbei_back.sv
// back end: body tables and the sequencer that carries out each command
module rbei_back #(
  parameter int BODY_COUNT    = rbei_pkg::BODY_COUNT_DEF,
  parameter int FRACTION_BITS = rbei_pkg::FRACTION_BITS_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             q_valid,
  input  rbei_pkg::cmd_t   q_cmd,
  output logic             q_take,
  output logic             out_valid,
  input  logic             out_stall,
  output rbei_pkg::res_t   res
);
  import rbei_pkg::*;

  localparam int AW = (BODY_COUNT > 1) ? $clog2(BODY_COUNT) : 1;
  localparam int SW = WORD_W;
  // 2t/5 as (t * ceil(2^34/5)) >> 33, exact for nonnegative 31-bit t
  localparam logic [63:0] RECIP5    = 64'h00000000cccccccd;
  localparam int          RECIP5_SH = 33;

  logic [SW-1:0]     mass_mem [BODY_COUNT];
  logic [SW-1:0]     rad_mem  [BODY_COUNT];
  logic [3*SW-1:0]   pos_mem  [BODY_COUNT];
  logic [3*SW-1:0]   vel_mem  [BODY_COUNT];
  logic [3*SW-1:0]   mom_mem  [BODY_COUNT];
  logic [3*SW-1:0]   spin_mem [BODY_COUNT];

  seq_t state_r, state_nxt;
  cmd_t cmd_r;
  logic [AW-1:0] addr;
  logic [SW-1:0] m_rd, r_rd;
  logic [3*SW-1:0] p_rd, v_rd, l_rd, s_rd;

  logic signed [SW-1:0] p_r [3];
  logic signed [SW-1:0] v_r [3];
  logic signed [SW-1:0] l_r [3];
  logic signed [SW-1:0] s_r [3];
  logic signed [SW-1:0] f_r [3];
  logic signed [SW-1:0] tq_r [3];
  logic [SW-1:0] m_r, r_r;
  logic signed [SW-1:0] acc_r, t_r, inertia_r;
  logic signed [63:0] prod_r;
  logic [1:0] ax_r;
  logic sat_r, tq_nz_r;
  logic out_valid_r;
  res_t res_r;
  logic we_r;

  logic signed [SW-1:0] mul_a, mul_b;
  logic signed [63:0] mul_p;
  logic [WORD_W:0] mq, addv, negv, iv;
  logic signed [63:0] mag_sh;
  logic signed [SW-1:0] div_num;
  logic [SW-1:0] div_den;
  logic div_start, div_done, div_sat;
  logic signed [SW-1:0] div_q;
  logic signed [63:0] tmp2;
  logic ax_last;

  // product path: multiply, then register; scaling and clamp happen next cycle
  assign mul_p  = mul_a * mul_b;
  assign mag_sh = prod_r[63] ? -$signed(64'((-prod_r) >>> FRACTION_BITS))
                             : (prod_r >>> FRACTION_BITS);
  assign mq     = sat32(mag_sh);
  assign ax_last = (ax_r == 2'd2);

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_r)
      ST_VEL_MUL: begin mul_a = acc_r;    mul_b = SW'(cmd_r.dt); end
      ST_POS_MUL: begin mul_a = v_r[ax_r]; mul_b = SW'(cmd_r.dt); end
      ST_TQ_MUL:  begin mul_a = r_r; mul_b = (ax_r == 2'd0) ? f_r[2] : f_r[0]; end
      ST_MR_MUL:  begin mul_a = m_r; mul_b = r_r; end
      ST_MRR_MUL: begin mul_a = t_r; mul_b = r_r; end
      ST_L_MUL:   begin mul_a = tq_r[ax_r]; mul_b = SW'(cmd_r.dt); end
      default: ;
    endcase
  end

  assign div_num = (state_r == ST_ACC_DIV) ? f_r[ax_r] : l_r[ax_r];
  assign div_den = (state_r == ST_ACC_DIV) ? m_r : inertia_r;
  assign div_start = (state_r == ST_ACC_DIV) || (state_r == ST_SPIN_DIV);

  rbei_div #(.FRACTION_BITS(FRACTION_BITS)) u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start), .num(div_num), .den(div_den),
    .done(div_done), .quo(div_q), .sat(div_sat)
  );

  assign addr = AW'(cmd_r.body);

  always_ff @(posedge clk) begin
    m_rd <= mass_mem[addr];
    r_rd <= rad_mem[addr];
    p_rd <= pos_mem[addr];
    v_rd <= vel_mem[addr];
    l_rd <= mom_mem[addr];
    s_rd <= spin_mem[addr];
    if (we_r) begin
      mass_mem[addr] <= m_r;
      rad_mem[addr]  <= r_r;
      pos_mem[addr]  <= {p_r[2], p_r[1], p_r[0]};
      vel_mem[addr]  <= {v_r[2], v_r[1], v_r[0]};
      mom_mem[addr]  <= {l_r[2], l_r[1], l_r[0]};
      spin_mem[addr] <= {s_r[2], s_r[1], s_r[0]};
    end
  end

  always_comb begin
    state_nxt = state_r;
    q_take = 1'b0;
    case (state_r)
      ST_IDLE: if (q_valid && !out_valid_r) begin
        q_take = 1'b1;
        state_nxt = ST_READ;
      end
      ST_READ:  state_nxt = ST_LATCH;
      ST_LATCH: begin
        if (!cmd_r.in_range) state_nxt = ST_OUT;
        else if (cmd_r.kind == KIND_STEP) state_nxt = ST_ACC_DIV;
        else if (cmd_r.kind == KIND_NONE) state_nxt = ST_OUT;
        else state_nxt = ST_WRITE;
      end
      ST_ACC_DIV: state_nxt = (m_r == '0) ? ST_VEL_MUL : ST_ACC_WAIT;
      ST_ACC_WAIT: if (div_done) state_nxt = ST_VEL_MUL;
      ST_VEL_MUL: state_nxt = ST_VEL_ADD;
      ST_VEL_ADD: state_nxt = ST_POS_MUL;
      ST_POS_MUL: state_nxt = ST_POS_ADD;
      ST_POS_ADD: state_nxt = ax_last ? ST_TQ_MUL : ST_ACC_DIV;
      ST_TQ_MUL:  state_nxt = ST_TQ_NEG;
      ST_TQ_NEG:  state_nxt = (ax_r == 2'd0) ? ST_TQ_MUL : ST_MR_MUL;
      ST_MR_MUL:  state_nxt = tq_nz_r ? ST_MR_LATCH : ST_WRITE;
      ST_MR_LATCH: state_nxt = ST_MRR_MUL;
      ST_MRR_MUL: state_nxt = ST_INERTIA;
      ST_INERTIA: state_nxt = ST_DIV5;
      ST_DIV5:    state_nxt = ST_L_MUL;
      ST_L_MUL:   state_nxt = ST_L_ADD;
      ST_L_ADD:   state_nxt = !ax_last ? ST_L_MUL :
                              (inertia_r > 0) ? ST_SPIN_DIV : ST_WRITE;
      ST_SPIN_DIV: state_nxt = ST_SPIN_WAIT;
      ST_SPIN_WAIT: if (div_done) state_nxt = ax_last ? ST_WRITE : ST_SPIN_DIV;
      ST_WRITE: state_nxt = ST_OUT;
      ST_OUT:   state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else        state_r <= state_nxt;
  end

  always_ff @(posedge clk) begin
    we_r <= (state_r == ST_WRITE);
    prod_r <= mul_p;
    case (state_r)
      ST_IDLE: if (q_take) begin
        cmd_r <= q_cmd;
        sat_r <= 1'b0;
      end
      ST_LATCH: begin
        ax_r <= 2'd0;
        tq_nz_r <= 1'b0;
        f_r[0] <= cmd_r.vx; f_r[1] <= cmd_r.vy; f_r[2] <= cmd_r.vz;
        if (!cmd_r.in_range) begin
          m_r <= m_rd; r_r <= r_rd;
          for (int i = 0; i < 3; i++) begin
            p_r[i] <= '0; v_r[i] <= '0; s_r[i] <= '0;
            l_r[i] <= l_rd[i*SW +: SW];
          end
        end else if (cmd_r.kind == KIND_LOAD) begin
          m_r <= {1'b0, cmd_r.mass};
          r_r <= {1'b0, cmd_r.radius};
          p_r[0] <= cmd_r.vx; p_r[1] <= cmd_r.vy; p_r[2] <= cmd_r.vz;
          for (int i = 0; i < 3; i++) begin
            v_r[i] <= '0; l_r[i] <= '0; s_r[i] <= '0;
          end
        end else begin
          m_r <= m_rd; r_r <= r_rd;
          for (int i = 0; i < 3; i++) begin
            p_r[i] <= p_rd[i*SW +: SW];
            l_r[i] <= l_rd[i*SW +: SW];
            s_r[i] <= s_rd[i*SW +: SW];
          end
          if (cmd_r.kind == KIND_SETV) begin
            v_r[0] <= cmd_r.vx; v_r[1] <= cmd_r.vy; v_r[2] <= cmd_r.vz;
          end else begin
            for (int i = 0; i < 3; i++) v_r[i] <= v_rd[i*SW +: SW];
          end
        end
      end
      ST_ACC_DIV: acc_r <= '0;
      ST_ACC_WAIT: if (div_done) begin
        acc_r <= div_q;
        sat_r <= sat_r | div_sat;
      end
      ST_VEL_ADD: begin
        v_r[ax_r] <= addv[SW-1:0];
        sat_r <= sat_r | mq[SW] | addv[SW];
      end
      ST_POS_ADD: begin
        p_r[ax_r] <= addv[SW-1:0];
        sat_r <= sat_r | mq[SW] | addv[SW];
        ax_r <= ax_last ? 2'd0 : ax_r + 2'd1;
      end
      ST_TQ_NEG: begin
        if (ax_r == 2'd0) begin
          tq_r[0] <= mq[SW-1:0];
          sat_r <= sat_r | mq[SW];
          tq_nz_r <= (mq[SW-1:0] != '0);
          ax_r <= 2'd2;
        end else begin
          tq_r[2] <= negv[SW-1:0];
          tq_r[1] <= '0;
          sat_r <= sat_r | mq[SW] | negv[SW];
          tq_nz_r <= tq_nz_r | (negv[SW-1:0] != '0);
          ax_r <= 2'd0;
        end
      end
      ST_MR_LATCH: begin
        t_r <= mq[SW-1:0];
        sat_r <= sat_r | mq[SW];
      end
      ST_INERTIA: begin
        t_r <= mq[SW-1:0];
        sat_r <= sat_r | mq[SW];
      end
      ST_DIV5: begin
        inertia_r <= iv[SW-1:0];
        sat_r <= sat_r | iv[SW];
      end
      ST_L_ADD: begin
        l_r[ax_r] <= addv[SW-1:0];
        sat_r <= sat_r | mq[SW] | addv[SW];
        ax_r <= ax_last ? 2'd0 : ax_r + 2'd1;
      end
      ST_SPIN_WAIT: if (div_done) begin
        s_r[ax_r] <= div_q;
        sat_r <= sat_r | div_sat;
        ax_r <= ax_last ? 2'd0 : ax_r + 2'd1;
      end
      default: ;
    endcase
  end

  // shared adder for the clamped sums, plus the torque negation and the 2/5 inertia scaling
  always_comb begin
    logic signed [SW-1:0] base;
    base = (state_r == ST_VEL_ADD) ? v_r[ax_r] :
           (state_r == ST_POS_ADD) ? p_r[ax_r] : l_r[ax_r];
    addv = sat32(64'(base) + 64'($signed(mq[SW-1:0])));
    negv = sat32(-64'($signed(mq[SW-1:0])));
    tmp2 = $signed(64'(t_r[SW-2:0]) * RECIP5);
    iv   = sat32(tmp2 >>> RECIP5_SH);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else if (state_r == ST_OUT) out_valid_r <= 1'b1;
    else if (out_valid_r && !out_stall) out_valid_r <= 1'b0;
    if (state_r == ST_OUT) begin
      res_r.body <= cmd_r.body;
      res_r.px <= p_r[0]; res_r.py <= p_r[1]; res_r.pz <= p_r[2];
      res_r.vx <= v_r[0]; res_r.vy <= v_r[1]; res_r.vz <= v_r[2];
      res_r.sx <= s_r[0]; res_r.sy <= s_r[1]; res_r.sz <= s_r[2];
      res_r.sat <= sat_r;
    end
  end

  assign out_valid = out_valid_r;
  assign res = res_r;

endmodule

### tb/tb_top.sv
// self-checking testbench for the sphere body integrator with a behavioral predictor
module tb_top;
  import rbei_pkg::*;

  localparam int NUM_RANDOM = 1750;
  localparam int WATCHDOG   = 20000;
  localparam longint MAX32  = 64'sd2147483647;
  localparam longint MIN32  = -64'sd2147483648;

  typedef struct {
    kind_t       kind;
    logic [5:0]  body;
    logic [31:0] vx, vy, vz;
    logic [30:0] mass, radius;
    logic [16:0] dt;
  } body_cmd_t;

  typedef struct {
    logic [5:0]  body;
    logic [31:0] f [9];
    logic        sat;
  } body_state_t;

  logic clk, rst_n;
  logic in_valid, in_stall, out_valid, out_stall;
  logic [1:0] in_kind;
  logic [5:0] in_body;
  logic signed [31:0] in_vector_x, in_vector_y, in_vector_z;
  logic [30:0] in_new_mass, in_new_radius;
  logic [16:0] in_step_time;
  logic [5:0] out_body_out;
  logic signed [31:0] out_pos_x, out_pos_y, out_pos_z, out_vel_x, out_vel_y, out_vel_z;
  logic signed [31:0] out_spin_x, out_spin_y, out_spin_z;
  logic out_saturated;

  rigid_body_euler_integrator DUT (.*);

  body_cmd_t   pending_cmds [$];
  body_state_t expected_states [$];
  longint mass_mem [64], radius_mem [64];
  longint pos_mem [64][3], vel_mem [64][3], mom_mem [64][3], spin_mem [64][3];
  bit loaded [64];
  int errors, idle_cycles, n_sats, hold_cycles;
  bit quiet_idle, hold_req;
  bit stim_done;
  bit in_fire;

  function automatic longint clamp(longint v, ref bit flag);
    if (v > MAX32) begin flag = 1; return MAX32; end
    if (v < MIN32) begin flag = 1; return MIN32; end
    return v;
  endfunction

  function automatic longint fx_mul(longint a, longint b, ref bit flag);
    longint p, q;
    p = a * b;
    q = (p < 0) ? -((-p) >>> 16) : (p >>> 16);
    return clamp(q, flag);
  endfunction

  function automatic longint fx_div(longint num, longint den, ref bit flag);
    longint mag, q;
    mag = (num < 0) ? -num : num;
    q = (mag <<< 16) / den;
    if (q > 64'h80000000) q = 64'h80000000;
    return clamp((num < 0) ? -q : q, flag);
  endfunction

  function automatic body_state_t integrate_body(body_cmd_t c);
    body_state_t s;
    bit flag;
    longint vec [3], a, m, r, dt, t, inertia, tq [3];
    int b;
    flag = 0;
    b = c.body;
    vec[0] = longint'($signed(c.vx));
    vec[1] = longint'($signed(c.vy));
    vec[2] = longint'($signed(c.vz));
    if (c.kind == KIND_LOAD) begin
      mass_mem[b] = c.mass;
      radius_mem[b] = c.radius;
      for (int i = 0; i < 3; i++) begin
        pos_mem[b][i] = vec[i]; vel_mem[b][i] = 0; mom_mem[b][i] = 0; spin_mem[b][i] = 0;
      end
    end else if (c.kind == KIND_SETV) begin
      for (int i = 0; i < 3; i++) vel_mem[b][i] = vec[i];
    end else if (c.kind == KIND_STEP) begin
      dt = c.dt; m = mass_mem[b]; r = radius_mem[b];
      for (int i = 0; i < 3; i++) begin
        a = 0;
        if (m > 0) a = fx_div(vec[i], m, flag);
        vel_mem[b][i] = clamp(vel_mem[b][i] + fx_mul(a, dt, flag), flag);
        pos_mem[b][i] = clamp(pos_mem[b][i] + fx_mul(vel_mem[b][i], dt, flag), flag);
      end
      tq[0] = fx_mul(r, vec[2], flag);
      tq[1] = 0;
      tq[2] = clamp(-fx_mul(r, vec[0], flag), flag);
      if (tq[0] != 0 || tq[2] != 0) begin
        for (int i = 0; i < 3; i++)
          mom_mem[b][i] = clamp(mom_mem[b][i] + fx_mul(tq[i], dt, flag), flag);
        t = fx_mul(m, r, flag);
        t = fx_mul(t, r, flag);
        inertia = clamp((t * 2) / 5, flag);
        if (inertia > 0)
          for (int i = 0; i < 3; i++) spin_mem[b][i] = fx_div(mom_mem[b][i], inertia, flag);
      end
    end
    s.body = c.body;
    for (int i = 0; i < 3; i++) begin
      s.f[i] = pos_mem[b][i][31:0];
      s.f[3+i] = vel_mem[b][i][31:0];
      s.f[6+i] = spin_mem[b][i][31:0];
    end
    s.sat = flag;
    return s;
  endfunction

  function automatic logic [31:0] rand_word();
    case ($urandom_range(0, 5))
      0: return 32'h7fffffff;
      1: return 32'h80000000;
      2: return $urandom_range(0, 8) << 16;
      3: return -($urandom_range(0, 8) << 16);
      4: return 32'(signed'($urandom_range(0, 20'hfffff)) - 20'sh80000);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [30:0] rand_mr();
    case ($urandom_range(0, 3))
      0: return 31'd655;
      1: return 31'h7fffffff;
      2: return 31'($urandom_range(655, 32'h40000));
      default: return 31'($urandom) | 31'd655;
    endcase
  endfunction

  task automatic queue_cmd(kind_t k, int b, logic [31:0] x, y, z,
                           logic [30:0] m, r, logic [16:0] dt);
    body_cmd_t c;
    c.kind = k; c.body = 6'(b); c.vx = x; c.vy = y; c.vz = z;
    c.mass = m; c.radius = r; c.dt = dt;
    if (k == KIND_LOAD) loaded[b] = 1;
    pending_cmds.push_back(c);
  endtask

  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  initial begin
    int b;
    kind_t k;
    in_valid = 0; out_stall = 0; in_kind = 0; in_body = 0;
    in_vector_x = 0; in_vector_y = 0; in_vector_z = 0;
    in_new_mass = 0; in_new_radius = 0; in_step_time = 0;
    rst_n = 0;
    repeat (4) @(posedge clk);
    @(negedge clk) rst_n = 1;
    // directed extremes and special cases
    queue_cmd(KIND_LOAD, 0, 0, 0, 0, 31'd655, 31'd655, 0);
    queue_cmd(KIND_STEP, 0, 32'h00010000, 0, 32'h00010000, 0, 0, 17'd65536);
    queue_cmd(KIND_LOAD, 63, 32'h7fffffff, 32'h80000000, 32'hffffffff,
              31'h7fffffff, 31'h7fffffff, 0);
    queue_cmd(KIND_SETV, 63, 32'h7fffffff, 32'h80000000, 0, 0, 0, 0);
    queue_cmd(KIND_STEP, 63, 32'h7fffffff, 32'h80000000, 32'h7fffffff,
              0, 0, 17'd65536);
    queue_cmd(KIND_STEP, 63, 32'h80000000, 32'h7fffffff, 32'h80000000,
              0, 0, 17'h1ffff);
    queue_cmd(KIND_STEP, 0, 0, 32'h00050000, 0, 0, 0, 17'd32768);
    queue_cmd(KIND_STEP, 0, 32'h12345, 0, 0, 0, 0, 0);
    queue_cmd(KIND_NONE, 0, 32'hffffffff, 32'hffffffff, 32'hffffffff,
              31'h7fffffff, 31'h7fffffff, 17'h1ffff);
    queue_cmd(KIND_LOAD, 5, 32'h00010000, 0, 0, 31'h7fffffff, 31'd655, 0);
    queue_cmd(KIND_STEP, 5, 32'h7fffffff, 0, 32'h7fffffff, 0, 0, 17'd65536);
    queue_cmd(KIND_LOAD, 6, 0, 0, 0, 31'd655, 31'h7fffffff, 0);
    queue_cmd(KIND_STEP, 6, 32'h80000000, 32'h80000000, 32'h80000000, 0, 0, 17'd1);
    queue_cmd(KIND_SETV, 6, 32'h80000000, 32'h80000000, 32'h80000000, 0, 0, 0);
    queue_cmd(KIND_STEP, 6, 32'h80000000, 32'h80000000, 32'h80000000, 0, 0, 17'd65536);
    for (int i = 0; i < NUM_RANDOM; i++) begin
      b = (i % 97 == 0) ? $urandom_range(16, 63) : $urandom_range(0, 15);
      if (!loaded[b] || $urandom_range(0, 99) < 12) k = KIND_LOAD;
      else begin
        case ($urandom_range(0, 9))
          0, 1: k = KIND_SETV;
          2:    k = KIND_NONE;
          default: k = KIND_STEP;
        endcase
      end
      queue_cmd(k, b, rand_word(), rand_word(), rand_word(),
                rand_mr(), rand_mr(),
                ($urandom_range(0, 9) == 0) ? 17'h1ffff : 17'($urandom_range(0, 65536)));
    end
    stim_done = 1;
  end

  // input transfer seen at the rising edge
  always @(posedge clk) in_fire <= rst_n && in_valid && !in_stall;

  // input driver
  always @(negedge clk) begin
    if (rst_n) begin
      if (in_fire) begin
        expected_states.push_back(integrate_body(pending_cmds.pop_front()));
        if (pending_cmds.size() == 0 || (!quiet_idle && $urandom_range(0, 99) < 15))
          in_valid <= 0;
      end else if (!in_valid && pending_cmds.size() > 0 &&
                   (quiet_idle || $urandom_range(0, 99) >= 15))
        in_valid <= 1;
      if (pending_cmds.size() > 0) begin
        in_kind <= pending_cmds[0].kind;
        in_body <= pending_cmds[0].body;
        in_vector_x <= pending_cmds[0].vx;
        in_vector_y <= pending_cmds[0].vy;
        in_vector_z <= pending_cmds[0].vz;
        in_new_mass <= pending_cmds[0].mass;
        in_new_radius <= pending_cmds[0].radius;
        in_step_time <= pending_cmds[0].dt;
      end
    end
  end

  // output back-pressure with one long hold-off
  always @(negedge clk) begin
    if (rst_n) begin
      if (hold_cycles > 0) begin
        hold_cycles <= hold_cycles - 1;
        out_stall <= 1;
      end else if (hold_req && pending_cmds.size() < NUM_RANDOM / 2) begin
        hold_req <= 0;
        hold_cycles <= 3000;
        out_stall <= 1;
      end else
        out_stall <= !quiet_idle && ($urandom_range(0, 99) < 15);
      quiet_idle <= pending_cmds.size() < 1300 && pending_cmds.size() > 1000;
    end
  end

  initial hold_req = 1;

  // result monitor
  always @(posedge clk) begin
    body_state_t e;
    logic [31:0] got [9];
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (out_valid && !out_stall) begin
        got = '{out_pos_x, out_pos_y, out_pos_z, out_vel_x, out_vel_y, out_vel_z,
                out_spin_x, out_spin_y, out_spin_z};
        if (expected_states.size() == 0) begin
          $display("%0t: unexpected transfer body %0d", $time, out_body_out);
          errors++;
        end else begin
          e = expected_states.pop_front();
          if (e.sat) n_sats <= n_sats + 1;
          if (out_body_out !== e.body) begin
            $display("%0t: body exp %0d got %0d", $time, e.body, out_body_out);
            errors++;
          end
          for (int i = 0; i < 9; i++)
            if (got[i] !== e.f[i]) begin
              $display("%0t: field %0d exp %h got %h", $time, i, e.f[i], got[i]);
              errors++;
            end
          if (out_saturated !== e.sat) begin
            $display("%0t: saturated exp %b got %b", $time, e.sat, out_saturated);
            errors++;
          end
        end
      end
    end
  end

  initial begin
    wait (stim_done);
    while (pending_cmds.size() > 0 || expected_states.size() > 0) begin
      @(posedge clk);
      if (idle_cycles > WATCHDOG) begin
        $display("Simulation FAILED");
        $finish;
      end
    end
    repeat (400) @(posedge clk);
    $display("covered loads, velocity writes, steps, unused kinds and high-index bodies");
    $display("%0d results flagged saturation, one long output hold-off", n_sats);
    if (errors == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end

endmodule

### sim.f
src/rbei_pkg.sv
src/rbei_div.sv
src/rbei_front.sv
src/rbei_back.sv
src/rigid_body_euler_integrator.sv
tb/tb_top.sv
